// File: sv/dait_pkg.sv
// Shared types and constants for the disk adapter with interrupt timer.
// Used by every module of the block; depends on nothing.
package dait_pkg;

	localparam int unsigned SHORT_DELAY = 100;
	localparam int unsigned LONG_DELAY  = 150;
	localparam int unsigned SIDE_BYTES  = 65500;

	localparam logic [15:0] LAST_POSITION = 16'd64999;
	localparam logic [15:0] SIDE_LIMIT    = 16'(SIDE_BYTES);
	localparam logic [7:0]  SHORT_DLY     = 8'(SHORT_DELAY);
	localparam logic [7:0]  LONG_DLY      = 8'(LONG_DELAY);

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	// bus register map
	localparam logic [15:0] ADDR_FWD_LIMIT = 16'h4020;
	localparam logic [15:0] ADDR_LATCH_LO  = 16'h4020;
	localparam logic [15:0] ADDR_LATCH_HI  = 16'h4021;
	localparam logic [15:0] ADDR_TIMER_CTL = 16'h4022;
	localparam logic [15:0] ADDR_IO_EN     = 16'h4023;
	localparam logic [15:0] ADDR_WDATA     = 16'h4024;
	localparam logic [15:0] ADDR_CONTROL   = 16'h4025;
	localparam logic [15:0] ADDR_IRQ_STAT  = 16'h4030;
	localparam logic [15:0] ADDR_RDATA     = 16'h4031;
	localparam logic [15:0] ADDR_DRV_STAT  = 16'h4032;
	localparam logic [15:0] ADDR_EXT       = 16'h4033;

	// configuration register indexes
	localparam logic [1:0] CFG_DISK_INSERTED = 2'd0;
	localparam logic [1:0] CFG_DISK_SIDE     = 2'd1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  disk_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        forwarded;
		logic        timer_irq;
		logic        disk_irq;
		logic        mirroring;
		logic        disk_read_strobe;
		logic        disk_write_strobe;
		logic [15:0] disk_address;
		logic [15:0] disk_position;
	} result_t;

	typedef struct packed {
		logic       wr;
		logic [1:0] index;
		logic [3:0] data;
	} cfg_wr_t;

endpackage

// File: sv/disk_adapter_with_irq_timer.sv
// Disk drive adapter with a 16-bit interrupt timer behind bus registers.
// Input channel (in_valid / in_stall) carries one item per transfer: a tick
// of one CPU cycle, a bus read or a bus write, with the image byte at the
// current disk position in disk_byte. Output channel (out_valid / out_stall)
// returns one result per item: read data, interrupt levels, mirroring,
// disk strobes with their byte offset and the position after the item.
// The configuration channel (cfg_valid / cfg_ready, always ready) writes
// disk_inserted (index 0) and disk_side (index 1); the user must write them
// only while the block is idle, which the block does not enforce. An
// accepted item is registered, evaluated against the adapter state and its
// result is registered. One item per clock is sustained without receiver
// stalls: all item state updates are one logic pass between both registers.
// When the receiver stalls, the result register holds and the staged item
// waits; in_stall then rises only once that stage is also occupied.
// Reset clears all adapter state, the configuration and both valid flags.
module disk_adapter_with_irq_timer import dait_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  disk_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        forwarded,
	output logic        timer_irq,
	output logic        disk_irq,
	output logic        mirroring,
	output logic        disk_read_strobe,
	output logic        disk_write_strobe,
	output logic [15:0] disk_address,
	output logic [15:0] disk_position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	item_t   item, item_s1;
	result_t result, result_q;
	cfg_wr_t cfg;
	logic    valid_s1, advance, load;

	assign item = '{kind: kind, address: address, write_data: write_data,
		disk_byte: disk_byte};

	assign cfg_ready = 1'b1;
	assign cfg = '{wr: cfg_valid, index: cfg_index, data: cfg_data};

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	dait_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.advance (advance),
		.item    (item),
		.valid_s1(valid_s1),
		.item_s1 (item_s1)
	);

	dait_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.advance(advance),
		.item_s1(item_s1),
		.result (result)
	);

	dait_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.out_stall(out_stall),
		.result   (result),
		.valid_q  (out_valid),
		.result_q (result_q)
	);

	assign read_data         = result_q.read_data;
	assign forwarded         = result_q.forwarded;
	assign timer_irq         = result_q.timer_irq;
	assign disk_irq          = result_q.disk_irq;
	assign mirroring         = result_q.mirroring;
	assign disk_read_strobe  = result_q.disk_read_strobe;
	assign disk_write_strobe = result_q.disk_write_strobe;
	assign disk_address      = result_q.disk_address;
	assign disk_position     = result_q.disk_position;

endmodule

// File: sv/dait_in_reg.sv
// Input stage register of the disk adapter: holds one accepted item.
// Depends on dait_pkg.
module dait_in_reg import dait_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  logic  advance,
	input  item_t item,
	output logic  valid_s1,
	output item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// File: sv/dait_core.sv
// Adapter state, bus register decode, timer and disk position logic.
// Produces the result of the staged item; depends on dait_pkg.
module dait_core import dait_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    advance,
	input  item_t   item_s1,
	output result_t result
);

	logic        inserted_q;
	logic [3:0]  side_q;
	logic [15:0] latch_q, count_q, position_q;
	logic [1:0]  mode_q, skip_q;
	logic        io_en_q, timer_flag_q, disk_flag_q, mirror_q;
	logic [7:0]  control_q, delay_q, last_q;

	logic [15:0] latch_d, count_d, position_d, cnt_dec;
	logic [1:0]  mode_d, skip_d;
	logic        io_en_d, timer_flag_d, disk_flag_d, mirror_d;
	logic [7:0]  control_d, delay_d, last_d, rd, wd, status;
	logic        rs, ws;
	logic [15:0] da;
	logic        fwd;

	always_comb begin
		latch_d      = latch_q;
		count_d      = count_q;
		mode_d       = mode_q;
		io_en_d      = io_en_q;
		control_d    = control_q;
		position_d   = position_q;
		skip_d       = skip_q;
		delay_d      = delay_q;
		last_d       = last_q;
		timer_flag_d = timer_flag_q;
		disk_flag_d  = disk_flag_q;
		mirror_d     = mirror_q;
		rd  = 8'h00;
		rs  = 1'b0;
		ws  = 1'b0;
		da  = 16'h0000;
		wd  = item_s1.write_data;
		fwd = 1'b0;
		cnt_dec = count_q - 16'd1;
		status  = 8'h40;
		if (!inserted_q) begin
			status = status | 8'h05;
		end
		if (!inserted_q || !control_q[0] || control_q[1]) begin
			status = status | 8'h02;
		end

		case (item_s1.kind)
			KIND_TICK: begin
				if (mode_q[1] && count_q != 16'd0) begin
					count_d = cnt_dec;
					if (cnt_dec == 16'd0) begin
						if (mode_q[0]) begin
							count_d = latch_q;
						end else begin
							mode_d  = 2'd0;
							latch_d = 16'd0;
						end
						timer_flag_d = 1'b1;
					end
				end
				if (delay_q != 8'd0) begin
					delay_d = delay_q - 8'd1;
					if (delay_q == 8'd1 && control_q[7]) begin
						disk_flag_d = 1'b1;
					end
				end
			end
			KIND_READ, KIND_WRITE: begin
				if (item_s1.address < ADDR_FWD_LIMIT) begin
					fwd = 1'b1;
				end else if (item_s1.kind == KIND_READ) begin
					case (item_s1.address)
						ADDR_IRQ_STAT: begin
							rd = 8'h80;
							timer_flag_d = 1'b0;
							disk_flag_d  = 1'b0;
						end
						ADDR_RDATA: begin
							if (!inserted_q) begin
								rd = last_q;
							end else begin
								last_d = item_s1.disk_byte;
								rd = item_s1.disk_byte;
								rs = 1'b1;
								da = position_q;
								if (position_q < LAST_POSITION) begin
									position_d = position_q + 16'd1;
								end
								delay_d = SHORT_DLY;
								disk_flag_d = 1'b0;
							end
						end
						ADDR_DRV_STAT: rd = status;
						ADDR_EXT:      rd = 8'h80;
						default:       rd = item_s1.address[15:8];
					endcase
				end else begin
					case (item_s1.address)
						ADDR_LATCH_LO: begin
							timer_flag_d = 1'b0;
							latch_d = {latch_q[15:8], wd};
						end
						ADDR_LATCH_HI: begin
							timer_flag_d = 1'b0;
							latch_d = {wd, latch_q[7:0]};
						end
						ADDR_TIMER_CTL: begin
							timer_flag_d = 1'b0;
							mode_d  = wd[1:0];
							count_d = latch_q;
						end
						ADDR_IO_EN: io_en_d = wd[0];
						ADDR_WDATA: begin
							if (inserted_q && !control_q[2] && io_en_q
								&& position_q < SIDE_LIMIT) begin
								if (skip_q != 2'd0) begin
									skip_d = skip_q - 2'd1;
								end else if (position_q >= 16'd2) begin
									ws = 1'b1;
									da = position_q - 16'd2;
								end
							end
						end
						ADDR_CONTROL: begin
							disk_flag_d = 1'b0;
							mirror_d = ~wd[3];
							if (inserted_q) begin
								// rewind by two when leaving motor-on transfer mode
								if (!wd[6] && control_q[6] && !wd[4]) begin
									position_d = (position_q >= 16'd2)
										? position_q - 16'd2 : 16'd0;
									delay_d = LONG_DLY;
								end
								if (wd[1]) begin
									position_d = 16'd0;
									delay_d = LONG_DLY;
								end
								if (!wd[2]) begin
									skip_d = 2'd2;
								end
								if (wd[6]) begin
									delay_d = LONG_DLY;
								end
								control_d = wd;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase

		result.read_data         = rd;
		result.forwarded         = fwd;
		result.timer_irq         = timer_flag_d;
		result.disk_irq          = disk_flag_d;
		result.mirroring         = mirror_d;
		result.disk_read_strobe  = rs;
		result.disk_write_strobe = ws;
		result.disk_address      = da;
		result.disk_position     = position_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inserted_q <= 1'b0;
			side_q     <= 4'd0;
		end else if (cfg.wr) begin
			case (cfg.index)
				CFG_DISK_INSERTED: inserted_q <= cfg.data[0];
				CFG_DISK_SIDE:     side_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q      <= 16'd0;
			count_q      <= 16'd0;
			mode_q       <= 2'd0;
			io_en_q      <= 1'b0;
			control_q    <= 8'd0;
			position_q   <= 16'd0;
			skip_q       <= 2'd0;
			delay_q      <= 8'd0;
			last_q       <= 8'd0;
			timer_flag_q <= 1'b0;
			disk_flag_q  <= 1'b0;
			mirror_q     <= 1'b0;
		end else if (advance) begin
			latch_q      <= latch_d;
			count_q      <= count_d;
			mode_q       <= mode_d;
			io_en_q      <= io_en_d;
			control_q    <= control_d;
			position_q   <= position_d;
			skip_q       <= skip_d;
			delay_q      <= delay_d;
			last_q       <= last_d;
			timer_flag_q <= timer_flag_d;
			disk_flag_q  <= disk_flag_d;
			// side does not affect mirroring
			mirror_q     <= mirror_d ^ (side_q[0] & 1'b0);
		end
	end

endmodule

// File: sv/dait_out_reg.sv
// Result register of the disk adapter: holds one result until taken.
// Depends on dait_pkg.
module dait_out_reg import dait_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    out_stall,
	input  result_t result,
	output logic    valid_q,
	output result_t result_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// File: tb/sv/disk_adapter_with_irq_timer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for disk_adapter_with_irq_timer: a directed table and random
// scenes, each result checked against typed values or an in-bench adapter model.
// Depends on dait_pkg and the disk_adapter_with_irq_timer RTL.
module disk_adapter_with_irq_timer_tb;
	import dait_pkg::*;

	localparam logic [1:0] KIND_IDLE = 2'd3;	// unused kind, block leaves state alone
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic    with_disk;
		logic    fixed;
		item_t   it;
		result_t want;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [7:0]  disk_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        forwarded;
	logic        timer_irq;
	logic        disk_irq;
	logic        mirroring;
	logic        disk_read_strobe;
	logic        disk_write_strobe;
	logic [15:0] disk_address;
	logic [15:0] disk_position;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;

	// adapter model state
	logic        has_disk;
	logic [15:0] tmr_latch, tmr_count;
	logic [1:0]  tmr_mode;
	logic        io_en;
	logic [7:0]  ctrl;
	logic [15:0] pos;
	logic [1:0]  skips;
	logic [7:0]  dly, last_rd;
	logic        tmr_flag, dsk_flag, mir;

	result_t     due[$];
	step_row_t   plan[$];
	result_t     got, want;
	int          fed = 0;
	int          bad = 0;
	int          idle_cycles = 0;
	int          sink_run = 0;
	bit          sink_calm = 0, src_calm = 0;

	disk_adapter_with_irq_timer dut (.*);

	always #2 clk = ~clk;

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic string show(result_t r);
		return $sformatf("rd=%h fw=%b tirq=%b dirq=%b mir=%b rs=%b ws=%b addr=%h pos=%0d",
			r.read_data, r.forwarded, r.timer_irq, r.disk_irq, r.mirroring,
			r.disk_read_strobe, r.disk_write_strobe, r.disk_address, r.disk_position);
	endfunction

	task automatic adapter_reset();
		tmr_latch = '0; tmr_count = '0; tmr_mode = '0; io_en = 1'b0;
		ctrl = '0; pos = '0; skips = '0; dly = '0; last_rd = '0;
		tmr_flag = 1'b0; dsk_flag = 1'b0; mir = 1'b0;
		has_disk = 1'b0;
	endtask

	task automatic adapter_step(input item_t it, output result_t r);
		r = '0;
		if (it.kind == KIND_TICK) begin
			if (tmr_mode[1] && tmr_count != 16'd0) begin
				tmr_count = tmr_count - 16'd1;
				if (tmr_count == 16'd0) begin
					if (tmr_mode[0]) begin
						tmr_count = tmr_latch;
					end else begin
						tmr_mode = '0;
						tmr_latch = '0;
					end
					tmr_flag = 1'b1;
				end
			end
			if (dly != 8'd0) begin
				dly = dly - 8'd1;
				if (dly == 8'd0 && ctrl[7])
					dsk_flag = 1'b1;
			end
		end else if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
			if (it.address < ADDR_FWD_LIMIT) begin
				r.forwarded = 1'b1;
			end else if (it.kind == KIND_READ) begin
				case (it.address)
					ADDR_IRQ_STAT: begin
						tmr_flag = 1'b0;
						dsk_flag = 1'b0;
						r.read_data = 8'h80;
					end
					ADDR_RDATA: begin
						if (has_disk) begin
							last_rd = it.disk_byte;
							r.disk_read_strobe = 1'b1;
							r.disk_address = pos;
							if (pos < LAST_POSITION)
								pos = pos + 16'd1;
							dly = SHORT_DLY;
							dsk_flag = 1'b0;
						end
						r.read_data = last_rd;
					end
					ADDR_DRV_STAT: begin
						r.read_data = 8'h40;
						if (!has_disk)
							r.read_data |= 8'h05;
						if (!has_disk || !ctrl[0] || ctrl[1])
							r.read_data |= 8'h02;
					end
					ADDR_EXT: r.read_data = 8'h80;
					default: r.read_data = it.address[15:8];
				endcase
			end else begin
				case (it.address)
					ADDR_LATCH_LO: begin
						tmr_flag = 1'b0;
						tmr_latch[7:0] = it.write_data;
					end
					ADDR_LATCH_HI: begin
						tmr_flag = 1'b0;
						tmr_latch[15:8] = it.write_data;
					end
					ADDR_TIMER_CTL: begin
						tmr_flag = 1'b0;
						tmr_mode = it.write_data[1:0];
						tmr_count = tmr_latch;
					end
					ADDR_IO_EN: io_en = it.write_data[0];
					ADDR_WDATA: begin
						if (has_disk && !ctrl[2] && io_en && pos < SIDE_LIMIT) begin
							if (skips != 2'd0) begin
								skips = skips - 2'd1;
							end else if (pos >= 16'd2) begin
								r.disk_write_strobe = 1'b1;
								r.disk_address = pos - 16'd2;
							end
						end
					end
					ADDR_CONTROL: begin
						dsk_flag = 1'b0;
						mir = ~it.write_data[3];
						if (has_disk) begin
							// leaving read mode without a reset steps the head back two bytes
							if (!it.write_data[6] && ctrl[6] && !it.write_data[4]) begin
								pos = (pos >= 16'd2) ? pos - 16'd2 : 16'd0;
								dly = LONG_DLY;
							end
							if (it.write_data[1]) begin
								pos = '0;
								dly = LONG_DLY;
							end
							if (!it.write_data[2])
								skips = 2'd2;
							if (it.write_data[6])
								dly = LONG_DLY;
							ctrl = it.write_data;
						end
					end
					default: ;
				endcase
			end
		end
		r.timer_irq = tmr_flag;
		r.disk_irq = dsk_flag;
		r.mirroring = mir;
		r.disk_position = pos;
	endtask

	// drive one item, wait for it to be taken, then log its expected result
	task automatic feed(input item_t it, input logic fixed, input result_t typed_res);
		result_t exp_r;
		int gap;
		in_valid <= 1'b1;
		kind <= it.kind;
		address <= it.address;
		write_data <= it.write_data;
		disk_byte <= it.disk_byte;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		adapter_step(it, exp_r);
		due.push_back(fixed ? typed_res : exp_r);
		fed++;
		if ($urandom_range(0, 39) == 0)
			src_calm = !src_calm;
		gap = (src_calm || $urandom_range(0, 1) == 0) ? 0 : pick_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put(input logic [1:0] k, input logic [15:0] a, input logic [7:0] wd,
			input logic [7:0] db);
		item_t it;
		it.kind = k;
		it.address = a;
		it.write_data = wd;
		it.disk_byte = db;
		feed(it, 1'b0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic ins_v, input logic [3:0] side_v);
		for (int n = 0; n < 2; n++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (n == 0) ? CFG_DISK_INSERTED : CFG_DISK_SIDE;
			cfg_data <= (n == 0) ? {3'b000, ins_v} : side_v;
			do @(negedge clk); while (!cfg_ready);
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		has_disk = ins_v;
	endtask

	task automatic plan_row(input int with_disk, input int fixed, input logic [1:0] k,
			input logic [15:0] a, input logic [7:0] wd, input logic [7:0] db,
			input int rd, input int fw, input int mr);
		step_row_t r;
		r = '0;
		r.with_disk = 1'(with_disk);
		r.fixed = 1'(fixed);
		r.it.kind = k;
		r.it.address = a;
		r.it.write_data = wd;
		r.it.disk_byte = db;
		r.want.read_data = 8'(rd);
		r.want.forwarded = 1'(fw);
		r.want.mirroring = 1'(mr);
		plan.push_back(r);
	endtask

	task automatic noise();
		logic [15:0] a;
		case ($urandom_range(0, 3))
			0, 1: a = 16'(ADDR_LATCH_LO + $urandom_range(0, 19));
			2: a = 16'($urandom_range(0, 16'h401F));
			default: a = rnd16();
		endcase
		put(2'($urandom_range(0, 3)), a, rnd8(), rnd8());
	endtask

	// short well-formed register sequences with random content
	task automatic scene();
		int n;
		n = $urandom_range(0, 19);
		if (n < 5) begin
			put(KIND_WRITE, ADDR_LATCH_LO, 8'($urandom_range(1, 40)), rnd8());
			put(KIND_WRITE, ADDR_LATCH_HI, ($urandom_range(0, 9) == 0) ? rnd8() : 8'h00,
				rnd8());
			put(KIND_WRITE, ADDR_TIMER_CTL, rnd8(), rnd8());
			repeat ($urandom_range(1, 60))
				put(KIND_TICK, rnd16(), rnd8(), rnd8());
		end else if (n < 10) begin
			repeat ($urandom_range(1, 6)) begin
				put(KIND_READ, ADDR_RDATA, rnd8(), rnd8());
				if ($urandom_range(0, 2) == 0)
					put(KIND_TICK, rnd16(), rnd8(), rnd8());
			end
		end else if (n < 15) begin
			put(KIND_WRITE, ADDR_IO_EN, ($urandom_range(0, 4) == 0) ? rnd8() : 8'h01, rnd8());
			put(KIND_WRITE, ADDR_CONTROL,
				rnd8() & (($urandom_range(0, 9) < 7) ? 8'hFB : 8'hFF), rnd8());
			repeat ($urandom_range(1, 5))
				put(KIND_WRITE, ADDR_WDATA, rnd8(), rnd8());
		end else if (n == 15) begin
			// let the disk delay run out with interrupts enabled
			put(KIND_WRITE, ADDR_CONTROL, rnd8() | 8'h80, rnd8());
			put(KIND_READ, ADDR_RDATA, rnd8(), rnd8());
			repeat ($urandom_range(95, 110))
				put(KIND_TICK, rnd16(), rnd8(), rnd8());
			put(KIND_READ, ADDR_IRQ_STAT, rnd8(), rnd8());
		end else begin
			put(KIND_READ, ADDR_DRV_STAT, rnd8(), rnd8());
			put(KIND_READ, ADDR_IRQ_STAT, rnd8(), rnd8());
			put(KIND_READ, 16'(ADDR_LATCH_LO + $urandom_range(0, 255)), rnd8(), rnd8());
		end
	endtask

	always @(posedge clk) begin
		if (sink_run > 0) begin
			sink_run--;
		end else if (sink_calm || $urandom_range(0, 1) == 0) begin
			out_stall <= 1'b0;
			sink_run = $urandom_range(0, 12);
			if ($urandom_range(0, 24) == 0)
				sink_calm = !sink_calm;
		end else begin
			out_stall <= 1'b1;
			sink_run = pick_len() - 1;
		end
	end

	// outputs are stable at the falling edge; a result seen here is taken at the next rise
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = {read_data, forwarded, timer_irq, disk_irq, mirroring, disk_read_strobe,
				disk_write_strobe, disk_address, disk_position};
			if (due.size() == 0) begin
				if (bad < MAX_SHOWN)
					$display("unexpected result: %s", show(got));
				bad++;
			end else begin
				want = due.pop_front();
				if (got !== want) begin
					if (bad < MAX_SHOWN)
						$display("mismatch: expected %s, got %s", show(want), show(got));
					bad++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int target;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		address = '0;
		write_data = '0;
		disk_byte = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DISK_INSERTED;
		cfg_data = '0;
		adapter_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(1'b0, 4'd0);

		// no disk: answers are fixed straight after reset
		plan_row(0, 1, KIND_READ, ADDR_IRQ_STAT, 8'h00, 8'h00, 8'h80, 0, 0);
		plan_row(0, 1, KIND_READ, ADDR_EXT, 8'h00, 8'h00, 8'h80, 0, 0);
		plan_row(0, 1, KIND_READ, ADDR_DRV_STAT, 8'h00, 8'h00, 8'h47, 0, 0);
		plan_row(0, 1, KIND_READ, ADDR_LATCH_LO, 8'h00, 8'h00, 8'h40, 0, 0);
		plan_row(0, 1, KIND_READ, 16'hFFFF, 8'h00, 8'h00, 8'hFF, 0, 0);
		plan_row(0, 1, KIND_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 1, 0);
		plan_row(0, 1, KIND_WRITE, 16'h401F, 8'hFF, 8'hFF, 8'h00, 1, 0);
		plan_row(0, 1, KIND_IDLE, 16'hFFFF, 8'hFF, 8'hFF, 8'h00, 0, 0);
		plan_row(0, 1, KIND_READ, ADDR_RDATA, 8'h00, 8'hAA, 8'h00, 0, 0);
		plan_row(0, 1, KIND_WRITE, ADDR_CONTROL, 8'h00, 8'h00, 8'h00, 0, 1);
		plan_row(0, 1, KIND_WRITE, ADDR_CONTROL, 8'hFF, 8'h00, 8'h00, 0, 0);
		// disk in: skips, writes near the start, timer, rewind and its clamp
		plan_row(1, 0, KIND_WRITE, ADDR_CONTROL, 8'h00, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_IO_EN, 8'h01, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_WDATA, 8'h11, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_WDATA, 8'h22, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_WDATA, 8'h33, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_READ, ADDR_RDATA, 8'h00, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_READ, ADDR_RDATA, 8'h00, 8'hFF, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_WDATA, 8'h5A, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_LATCH_LO, 8'h02, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_TIMER_CTL, 8'hFF, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_TICK, 16'h0000, 8'h00, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_TICK, 16'hFFFF, 8'hFF, 8'hFF, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_CONTROL, 8'hC5, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_CONTROL, 8'h85, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_CONTROL, 8'h87, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_CONTROL, 8'hC4, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_WRITE, ADDR_CONTROL, 8'h84, 8'h00, 0, 0, 0);
		plan_row(1, 0, KIND_READ, ADDR_DRV_STAT, 8'h00, 8'h00, 0, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].with_disk != has_disk) begin
				drain();
				configure(plan[i].with_disk, 4'd15);
			end
			feed(plan[i].it, plan[i].fixed, plan[i].want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: configure(1'b1, 4'd0);
				1: configure(1'b0, 4'd15);
				2: configure(1'b1, 4'd15);
				default: configure(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
			endcase
			target = fed + 120;
			while (fed < target) begin
				if ($urandom_range(0, 9) < 7)
					scene();
				else
					noise();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (bad == 0 && due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
